// ===== sv/http_request_head_tokenizer_assert.svh =====
// Assertion macros for the HTTP request head tokenizer.
// Depends on nothing; compiled out when SYNTHESIS is defined.
`ifndef HTTP_REQUEST_HEAD_TOKENIZER_ASSERT_SVH
`define HTTP_REQUEST_HEAD_TOKENIZER_ASSERT_SVH

`ifndef SYNTHESIS
`define HRT_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hrt: same-cycle check failed");
`define HRT_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hrt: next-cycle check failed");
`else
`define HRT_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define HRT_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

// ===== sv/hrt_pkg.sv =====
// Types, codes and method table for the HTTP request head tokenizer.
// Depends on nothing.
package hrt_pkg;

  localparam int NUM_VERBS = 5;

  typedef enum logic [2:0] {
    ST_METHOD  = 3'd0,
    ST_PATH    = 3'd1,
    ST_VERSION = 3'd2,
    ST_HNAME   = 3'd3,
    ST_HVALUE  = 3'd4,
    ST_BODY    = 3'd5
  } parse_state_t;

  localparam logic [2:0] KIND_METHOD  = 3'd0;
  localparam logic [2:0] KIND_PATH    = 3'd1;
  localparam logic [2:0] KIND_VERSION = 3'd2;
  localparam logic [2:0] KIND_HNAME   = 3'd3;
  localparam logic [2:0] KIND_HVALUE  = 3'd4;
  localparam logic [2:0] KIND_BODY    = 3'd5;
  localparam logic [2:0] KIND_SEP     = 3'd6;
  localparam logic [2:0] KIND_CR      = 3'd7;

  localparam logic [2:0] VERB_GET    = 3'd0;
  localparam logic [2:0] VERB_POST   = 3'd1;
  localparam logic [2:0] VERB_PUT    = 3'd2;
  localparam logic [2:0] VERB_DELETE = 3'd3;
  localparam logic [2:0] VERB_PATCH  = 3'd4;
  localparam logic [2:0] CODE_UNKNOWN = 3'd5;

  localparam logic [2:0] METHOD_LEN_MAX = 3'd7;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  localparam logic [2:0] VERB_LEN [NUM_VERBS] = '{3'd3, 3'd4, 3'd3, 3'd6, 3'd5};

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_message;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic [2:0] field_kind;
    logic       field_done;
    logic [2:0] method_code;
    logic       method_valid;
    logic       head_done;
  } out_beat_t;

  typedef struct packed {
    parse_state_t           parse_state;
    logic [NUM_VERBS-1:0]   match_flags;
    logic [2:0]             method_len;
    logic                   cr_seen;
    logic                   skip_sp;
  } ctx_t;

  localparam ctx_t CTX_RESET = '{
    parse_state: ST_METHOD,
    match_flags: '1,
    method_len:  3'd0,
    cr_seen:     1'b0,
    skip_sp:     1'b0
  };

  function automatic logic [7:0] verb_char(input logic [2:0] verb, input logic [2:0] pos);
    logic [7:0] txt [6];
    txt = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    case (verb)
      VERB_GET:    txt = '{"G", "E", "T", 8'h00, 8'h00, 8'h00};
      VERB_POST:   txt = '{"P", "O", "S", "T", 8'h00, 8'h00};
      VERB_PUT:    txt = '{"P", "U", "T", 8'h00, 8'h00, 8'h00};
      VERB_DELETE: txt = '{"D", "E", "L", "E", "T", "E"};
      VERB_PATCH:  txt = '{"P", "A", "T", "C", "H", 8'h00};
      default:     txt = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    endcase
    case (pos)
      3'd0:    return txt[0];
      3'd1:    return txt[1];
      3'd2:    return txt[2];
      3'd3:    return txt[3];
      3'd4:    return txt[4];
      3'd5:    return txt[5];
      default: return 8'h00;
    endcase
  endfunction

endpackage

// ===== sv/hrt_classify.sv =====
// Per-byte tagging and parse state transition for one beat.
// Depends on hrt_pkg.
module hrt_classify
  import hrt_pkg::*;
(
  input  in_beat_t  beat,
  input  ctx_t      ctx,
  output ctx_t      ctx_nxt,
  output out_beat_t res
);

  ctx_t       cur;
  logic [7:0] b;

  assign b = beat.data_byte;

  always_comb begin
    cur = beat.start_of_message ? CTX_RESET : ctx;
    ctx_nxt = cur;
    res.byte_out     = b;
    res.field_kind   = KIND_METHOD;
    res.field_done   = 1'b0;
    res.method_code  = CODE_UNKNOWN;
    res.method_valid = 1'b0;
    res.head_done    = 1'b0;

    unique case (cur.parse_state)
      ST_METHOD: begin
        if (b == CH_SPACE) begin
          for (int k = 0; k < NUM_VERBS; k++) begin
            if (cur.match_flags[k] && cur.method_len == VERB_LEN[k]) begin
              res.method_code = 3'(k);
            end
          end
          res.method_valid    = 1'b1;
          res.field_done      = 1'b1;
          res.field_kind      = KIND_SEP;
          ctx_nxt.parse_state = ST_PATH;
          ctx_nxt.match_flags = '1;
          ctx_nxt.method_len  = 3'd0;
        end else begin
          for (int k = 0; k < NUM_VERBS; k++) begin
            if (!(cur.method_len < VERB_LEN[k] && verb_char(3'(k), cur.method_len) == b)) begin
              ctx_nxt.match_flags[k] = 1'b0;
            end
          end
          if (cur.method_len != METHOD_LEN_MAX) begin
            ctx_nxt.method_len = cur.method_len + 3'd1;
          end
        end
      end
      ST_PATH: begin
        if (b == CH_SPACE) begin
          res.field_kind      = KIND_SEP;
          res.field_done      = 1'b1;
          ctx_nxt.parse_state = ST_VERSION;
        end else begin
          res.field_kind = KIND_PATH;
        end
      end
      ST_VERSION, ST_HNAME, ST_HVALUE: begin
        ctx_nxt.cr_seen = 1'b0;
        if (cur.cr_seen && b == CH_LF) begin
          res.field_kind = KIND_SEP;
          if (cur.parse_state == ST_HNAME) begin
            res.head_done       = 1'b1;
            ctx_nxt.parse_state = ST_BODY;
          end else begin
            res.field_done      = 1'b1;
            ctx_nxt.parse_state = ST_HNAME;
          end
        end else if (cur.parse_state == ST_HVALUE && cur.skip_sp && b == CH_SPACE) begin
          res.field_kind = KIND_SEP;
        end else begin
          if (cur.parse_state == ST_HVALUE) begin
            ctx_nxt.skip_sp = 1'b0;
          end
          if (b == CH_CR) begin
            ctx_nxt.cr_seen = 1'b1;
            res.field_kind  = KIND_CR;
          end else if (cur.parse_state == ST_HNAME && b == CH_COLON) begin
            res.field_kind      = KIND_SEP;
            res.field_done      = 1'b1;
            ctx_nxt.skip_sp     = 1'b1;
            ctx_nxt.parse_state = ST_HVALUE;
          end else if (cur.parse_state == ST_VERSION) begin
            res.field_kind = KIND_VERSION;
          end else if (cur.parse_state == ST_HNAME) begin
            res.field_kind = KIND_HNAME;
          end else begin
            res.field_kind = KIND_HVALUE;
          end
        end
      end
      default: begin
        res.field_kind = KIND_BODY;
      end
    endcase
  end

endmodule

// ===== sv/http_request_head_tokenizer.sv =====
// HTTP request head tokenizer: tags each request byte by message part.
// Path: a beat is held in the input register s0_r, classified, then captured in out_r.
// Throughput: one byte per cycle while out_stall is low; out_stall backs up into in_stall.
// Reset: rst_n low clears both valid stages and returns the parser to method state.
// Depends on hrt_pkg, hrt_classify and http_request_head_tokenizer_assert.svh.
`include "http_request_head_tokenizer_assert.svh"

module http_request_head_tokenizer
  import hrt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);

  in_beat_t  s0_r;
  logic      s0_valid_r;
  logic      s0_valid_nxt;
  out_beat_t out_r;
  logic      out_valid_r;
  logic      out_valid_nxt;
  ctx_t      ctx_r;
  ctx_t      ctx_nxt;
  out_beat_t res;
  logic      s0_adv;
  logic      in_acc;

  hrt_classify u_classify (
    .beat    (s0_r),
    .ctx     (ctx_r),
    .ctx_nxt (ctx_nxt),
    .res     (res)
  );

  assign s0_adv   = s0_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s0_valid_r && !s0_adv;
  assign in_acc   = in_valid && !in_stall;

  assign s0_valid_nxt  = in_acc ? 1'b1 : (s0_adv ? 1'b0 : s0_valid_r);
  assign out_valid_nxt = s0_adv ? 1'b1 : (out_stall ? out_valid_r : 1'b0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      ctx_r       <= CTX_RESET;
    end else begin
      s0_valid_r  <= s0_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s0_adv) begin
        ctx_r <= ctx_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s0_r <= in_data;
    end
    if (s0_adv) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `HRT_ASSERT_IMPL(a_method_end_sep, clk, rst_n, out_valid_r && out_r.method_valid, out_r.field_done && out_r.field_kind == KIND_SEP)
  `HRT_ASSERT_NEXT(a_head_to_body, clk, rst_n, s0_adv && res.head_done, ctx_r.parse_state == ST_BODY)
  `HRT_ASSERT_NEXT(a_body_sticky, clk, rst_n, ctx_r.parse_state == ST_BODY && !(s0_adv && s0_r.start_of_message), ctx_r.parse_state == ST_BODY)

endmodule

// ===== dv/tb_http_request_head_tokenizer.sv =====
`timescale 1ns / 1ps
// Testbench for http_request_head_tokenizer: directed and random request bytes, with
// random idling and stalls on both channels, checked against a scoreboard predictor.
// Depends on hrt_pkg and the http_request_head_tokenizer RTL.
module tb_http_request_head_tokenizer;
  import hrt_pkg::*;

  localparam int RANDOM_BEATS    = 600;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int DRAIN_CYCLES    = 8;
  localparam int HOLD_OFF_AT     = 150;
  localparam int HOLD_OFF_CYCLES = 400;

  class head_tag_scoreboard;
    string                verb_names [NUM_VERBS];
    parse_state_t         state;
    logic [NUM_VERBS-1:0] verb_hits;
    logic [2:0]           token_len;
    logic                 cr_pending;
    logic                 skip_lead_sp;
    out_beat_t            pending_tags [$];
    int                   errors;

    function new();
      verb_names = '{"GET", "POST", "PUT", "DELETE", "PATCH"};
      errors = 0;
      restart();
    endfunction

    function void restart();
      state        = ST_METHOD;
      verb_hits    = '1;
      token_len    = 3'd0;
      cr_pending   = 1'b0;
      skip_lead_sp = 1'b0;
    endfunction

    function out_beat_t tag_byte(in_beat_t beat);
      out_beat_t  r;
      logic [7:0] b;
      int         k;
      if (beat.start_of_message) restart();
      b              = beat.data_byte;
      r.byte_out     = b;
      r.field_kind   = KIND_METHOD;
      r.field_done   = 1'b0;
      r.method_code  = CODE_UNKNOWN;
      r.method_valid = 1'b0;
      r.head_done    = 1'b0;
      case (state)
        ST_METHOD: begin
          if (b == CH_SPACE) begin
            for (k = 0; k < NUM_VERBS; k++)
              if (verb_hits[k] && token_len == verb_names[k].len()) r.method_code = 3'(k);
            r.method_valid = 1'b1;
            r.field_done   = 1'b1;
            r.field_kind   = KIND_SEP;
            state          = ST_PATH;
            verb_hits      = '1;
            token_len      = 3'd0;
          end else begin
            for (k = 0; k < NUM_VERBS; k++)
              if (!(token_len < verb_names[k].len() && verb_names[k][token_len] == b))
                verb_hits[k] = 1'b0;
            if (token_len < METHOD_LEN_MAX) token_len++;
          end
        end
        ST_PATH: begin
          if (b == CH_SPACE) begin
            r.field_kind = KIND_SEP;
            r.field_done = 1'b1;
            state        = ST_VERSION;
          end else begin
            r.field_kind = KIND_PATH;
          end
        end
        ST_VERSION, ST_HNAME, ST_HVALUE: begin
          if (cr_pending && b == CH_LF) begin
            cr_pending   = 1'b0;
            r.field_kind = KIND_SEP;
            if (state == ST_HNAME) begin
              r.head_done = 1'b1;
              state       = ST_BODY;
            end else begin
              r.field_done = 1'b1;
              state        = ST_HNAME;
            end
          end else begin
            cr_pending = 1'b0;
            if (state == ST_HVALUE && skip_lead_sp && b == CH_SPACE) begin
              r.field_kind = KIND_SEP;
            end else begin
              if (state == ST_HVALUE) skip_lead_sp = 1'b0;
              if (b == CH_CR) begin
                cr_pending   = 1'b1;
                r.field_kind = KIND_CR;
              end else if (state == ST_HNAME && b == CH_COLON) begin
                r.field_kind = KIND_SEP;
                r.field_done = 1'b1;
                skip_lead_sp = 1'b1;
                state        = ST_HVALUE;
              end else begin
                r.field_kind = state;
              end
            end
          end
        end
        default: r.field_kind = KIND_BODY;
      endcase
      return r;
    endfunction

    function void note_request_byte(in_beat_t beat);
      pending_tags = {pending_tags, tag_byte(beat)};
    endfunction

    function void check_tag(out_beat_t got);
      out_beat_t want;
      if (pending_tags.size() == 0) begin
        $error("result beat with no expectation, byte_out %02h", got.byte_out);
        errors++;
        return;
      end
      want = pending_tags.pop_front();
      if (got.byte_out !== want.byte_out) begin
        $error("byte_out: expected %02h, got %02h", want.byte_out, got.byte_out);
        errors++;
      end
      if (got.field_kind !== want.field_kind) begin
        $error("field_kind: expected %0d, got %0d", want.field_kind, got.field_kind);
        errors++;
      end
      if (got.field_done !== want.field_done) begin
        $error("field_done: expected %0d, got %0d", want.field_done, got.field_done);
        errors++;
      end
      if (got.method_code !== want.method_code) begin
        $error("method_code: expected %0d, got %0d", want.method_code, got.method_code);
        errors++;
      end
      if (got.method_valid !== want.method_valid) begin
        $error("method_valid: expected %0d, got %0d", want.method_valid, got.method_valid);
        errors++;
      end
      if (got.head_done !== want.head_done) begin
        $error("head_done: expected %0d, got %0d", want.head_done, got.head_done);
        errors++;
      end
    endfunction
  endclass

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_beat_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_data;

  head_tag_scoreboard sb = new();
  in_beat_t           req_beats [$];
  logic               first_sop;
  int                 beats_sent = 0;
  int                 send_run   = 0;

  http_request_head_tokenizer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function void add_byte(logic [7:0] b);
    in_beat_t beat;
    beat.data_byte        = b;
    beat.start_of_message = first_sop;
    req_beats = {req_beats, beat};
    first_sop = 1'b0;
  endfunction

  function void add_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  function void add_line_end();
    add_byte(CH_CR);
    add_byte(CH_LF);
  endfunction

  function void build_request();
    int    k;
    int    i;
    int    n;
    string s;
    first_sop = ($urandom_range(0, 7) != 0);
    k = $urandom_range(0, 6);
    if (k < NUM_VERBS) begin
      add_text(sb.verb_names[k]);
    end else if (k == NUM_VERBS) begin
      n = $urandom_range(0, 8);
      repeat (n) add_byte(8'($urandom_range(8'h41, 8'h5A)));
    end else begin
      s = sb.verb_names[$urandom_range(0, NUM_VERBS - 1)];
      if ($urandom_range(0, 1)) begin
        add_text(s.substr(0, s.len() - 2));
      end else begin
        add_text(s);
        add_byte("S");
      end
    end
    add_byte(CH_SPACE);
    add_byte("/");
    n = $urandom_range(0, 5);
    repeat (n) add_byte(8'($urandom_range(8'h21, 8'h7E)));
    add_byte(CH_SPACE);
    add_text("HTTP/1.1");
    add_line_end();
    k = $urandom_range(0, 3);
    for (i = 0; i < k; i++) begin
      n = $urandom_range(1, 6);
      repeat (n) add_byte(8'($urandom_range(8'h61, 8'h7A)));
      if ($urandom_range(0, 7) != 0) begin
        add_byte(CH_COLON);
        n = $urandom_range(0, 3);
        repeat (n) add_byte(CH_SPACE);
        n = $urandom_range(0, 6);
        repeat (n) add_byte(8'($urandom_range(8'h20, 8'h7E)));
        if ($urandom_range(0, 7) == 0) add_byte(CH_CR);
        n = $urandom_range(0, 2);
        repeat (n) add_byte(8'($urandom_range(8'h20, 8'h7E)));
      end
      add_line_end();
    end
    add_line_end();
    n = $urandom_range(0, 6);
    repeat (n) add_byte(8'($urandom_range(0, 255)));
  endfunction

  function void build_noise();
    int n;
    first_sop = ($urandom_range(0, 3) == 0);
    n = $urandom_range(1, 12);
    repeat (n) begin
      case ($urandom_range(0, 7))
        0:       add_byte(CH_CR);
        1:       add_byte(CH_LF);
        2:       add_byte(CH_SPACE);
        3:       add_byte(CH_COLON);
        default: add_byte(8'($urandom_range(0, 255)));
      endcase
    end
  endfunction

  task automatic send_beat(in_beat_t beat);
    int gap;
    if (send_run > 0) begin
      gap = 0;
      send_run--;
    end else begin
      gap = $urandom_range(0, 15);
      if ($urandom_range(0, 31) == 0) send_run = $urandom_range(20, 40);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (in_stall);
    sb.note_request_byte(beat);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic send_request();
    while (req_beats.size() > 0) send_beat(req_beats.pop_front());
  endtask

  initial begin : stimulus
    int directed_beats;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    first_sop = 1'b1;
    add_byte(CH_SPACE);
    add_byte(8'hFF);
    add_byte(CH_SPACE);
    add_byte(CH_CR);
    add_byte("A");
    add_line_end();
    add_line_end();
    add_byte(8'h00);
    add_byte(8'hFF);
    first_sop = 1'b1;
    add_text("GET ");
    first_sop = 1'b1;
    add_text("POST ");
    first_sop = 1'b1;
    add_text("PUT ");
    first_sop = 1'b1;
    add_text("DELETE ");
    first_sop = 1'b1;
    add_text("PATCHES ");
    first_sop = 1'b1;
    add_text("PATCH /");
    add_line_end();
    add_text(" v");
    add_line_end();
    add_text("h:  ");
    add_line_end();
    add_text("e:");
    add_line_end();
    add_text("n");
    add_line_end();
    add_text("b");
    send_request();
    directed_beats = beats_sent;

    while (beats_sent < directed_beats + RANDOM_BEATS) begin
      if ($urandom_range(0, 3) != 0) build_request();
      else build_noise();
      send_request();
    end
    in_valid <= 1'b0;

    while (sb.pending_tags.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin : result_sink
    int gap;
    int taken;
    int sink_run;
    bit held_off;
    taken    = 0;
    sink_run = 0;
    held_off = 1'b0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      if (sink_run > 0) begin
        gap = 0;
        sink_run--;
      end else begin
        gap = $urandom_range(0, 15);
        if ($urandom_range(0, 31) == 0) sink_run = $urandom_range(20, 40);
      end
      // hold off long enough to back the block up into its input
      if (taken == HOLD_OFF_AT && !held_off) begin
        gap      = HOLD_OFF_CYCLES;
        held_off = 1'b1;
      end
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      sb.check_tag(out_data);
      taken++;
      @(negedge clk);
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
      else idle++;
    end
    $display("FAIL");
    $finish;
  end

endmodule

// ===== http_request_head_tokenizer.f =====
+incdir+sv
sv/hrt_pkg.sv
sv/hrt_classify.sv
sv/http_request_head_tokenizer.sv
dv/tb_http_request_head_tokenizer.sv
